/* rtl/core/ehu_pkg.sv */
// ----------------------------------------------------------------------------
// ehu_pkg
// Shared types and codes for the EHABI frame unwind block.
// ----------------------------------------------------------------------------
package ehu_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_ENTRY = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic REG_STACK_BASE = 1'b0;
  localparam logic REG_STACK_TOP  = 1'b1;

  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_CANT    = 4'd1;
  localparam logic [3:0] ST_BADPERS = 4'd2;
  localparam logic [3:0] ST_REFUSE  = 4'd3;
  localparam logic [3:0] ST_SPARE   = 4'd4;
  localparam logic [3:0] ST_UNHAND  = 4'd5;
  localparam logic [3:0] ST_SPRANGE = 4'd6;
  localparam logic [3:0] ST_PCLOOP  = 4'd7;
  localparam logic [3:0] ST_OUTSIDE = 4'd8;

  localparam int unsigned IN_BITS = 2 + 8 + 32 * 5;

  // Item passed from the front to the back through the queue.
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  idx;
    logic [31:0] value;
    logic [31:0] fp;
    logic [31:0] sp;
    logic [31:0] lr;
    logic [31:0] pc;
  } item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] fp;
    logic [31:0] sp;
    logic [31:0] lr;
    logic [31:0] pc;
  } result_t;

endpackage

/* rtl/core/ehabi_unwind_interpreter_unit.sv */
// ----------------------------------------------------------------------------
// ehabi_unwind_interpreter_unit
// Single-frame EHABI compact-model unwinder.
// ----------------------------------------------------------------------------
// Input channel s_axis: tuser carries the operation (load word, begin frame,
// entry word); tdata carries stack index, value and the begin frame.
// Output channel m_axis: one result per finished frame or first error.
// Write stack_base (index 0) and stack_top (index 1) while idle.
// A front stage unpacks items into a two-entry queue; a back sequencer
// runs opcodes. Loads and begins pass the queue and are taken by the back
// while idle. An entry word is accepted; each opcode is fetched (with its
// operand byte for a two-byte opcode), executed and checked; each pop takes
// a read and a wait step, since it waits on the registered store read, and
// a last read step closes the pop, followed by the word end and frame finish.
// Reset clears the frame state and the queue; store contents stay undefined
// until loaded. While the result is not taken, the back holds and the
// queue fills, then s_axis_tready falls.
// ----------------------------------------------------------------------------
module ehabi_unwind_interpreter_unit #(
  parameter int unsigned STACK_WORDS = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: stack_index, value, frame_fp, frame_sp, frame_lr, frame_pc
  input  logic [167:0] s_axis_tdata,
  // tuser: operation
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status, new_fp, new_sp, new_lr, new_pc, 4 zero bits
  output logic [135:0] m_axis_tdata
);
  logic [31:0] base_q, top_q;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  ehu_pkg::item_t f_item, b_item;
  ehu_pkg::result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd0;
      top_q  <= 32'd0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == ehu_pkg::REG_STACK_TOP) top_q <= cfg_wdata_i;
      else base_q <= cfg_wdata_i;
    end
  end

  ehu_front u_front (
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .q_valid_o(fq_valid), .q_ready_i(fq_ready), .q_item_o(f_item)
  );

  ehu_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(fq_valid), .in_ready_o(fq_ready), .in_item_i(f_item),
    .out_valid_o(qb_valid), .out_ready_i(qb_ready), .out_item_o(b_item)
  );

  ehu_back #(.StackWords(STACK_WORDS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .stack_base_i(base_q), .stack_top_i(top_q),
    .q_valid_i(qb_valid), .q_ready_o(qb_ready), .q_item_i(b_item),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {4'd0, res.pc, res.lr, res.sp, res.fp, res.status};
endmodule

/* rtl/core/ehu_ram.sv */
// ----------------------------------------------------------------------------
// ehu_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ehu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* rtl/core/ehu_queue.sv */
// ----------------------------------------------------------------------------
// ehu_queue
// Two-entry item queue between the front and the back.
// ----------------------------------------------------------------------------
module ehu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ehu_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ehu_pkg::item_t out_item_o
);
  ehu_pkg::item_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end
endmodule

/* rtl/core/ehu_front.sv */
// ----------------------------------------------------------------------------
// ehu_front
// Input stage: unpacks stream items and drops those that do nothing.
// ----------------------------------------------------------------------------
module ehu_front (
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [167:0]   s_axis_tdata,
  input  logic [1:0]     s_axis_tuser,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output ehu_pkg::item_t q_item_o
);
  logic keep;

  assign q_item_o.op    = s_axis_tuser;
  assign q_item_o.idx   = s_axis_tdata[7:0];
  assign q_item_o.value = s_axis_tdata[39:8];
  assign q_item_o.fp    = s_axis_tdata[71:40];
  assign q_item_o.sp    = s_axis_tdata[103:72];
  assign q_item_o.lr    = s_axis_tdata[135:104];
  assign q_item_o.pc    = s_axis_tdata[167:136];

  // Drop the unused operation here without reaching the queue.
  assign keep = (s_axis_tuser != ehu_pkg::OP_NONE);
  assign q_valid_o = s_axis_tvalid && keep;
  assign s_axis_tready = q_ready_i || !keep;
endmodule

/* rtl/core/ehu_back.sv */
// ----------------------------------------------------------------------------
// ehu_back
// Opcode sequencer: runs entry words byte by byte, one pop per store read.
// ----------------------------------------------------------------------------
module ehu_back #(
  parameter int unsigned StackWords = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [31:0]      stack_base_i,
  input  logic [31:0]      stack_top_i,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  ehu_pkg::item_t   q_item_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output ehu_pkg::result_t res_o
);
  localparam int unsigned AW = $clog2(StackWords);

  typedef enum logic [2:0] {
    S_IDLE, S_BYTE, S_EXEC, S_READ, S_WAIT, S_CHECK, S_FIN, S_END
  } state_e;

  typedef enum logic [1:0] { PH_IDLE, PH_FIRST, PH_BODY } phase_e;

  state_e state_q;
  phase_e phase_q;
  logic [31:0] regs_q [16];
  logic [31:0] sp_low_q, sp_high_q, start_pc_q, word_q, vsp_q;
  logic [8:0]  words_left_q;
  logic [7:0]  pend_q, op_q, arg_q;
  logic        pend_v_q, flush_q;
  logic [1:0]  bidx_q;
  logic [2:0]  nbytes_q;
  logic [15:0] mask_q;
  logic [3:0]  dst_q;
  logic        set_sp_q, fin_q;
  logic        res_v_q;
  ehu_pkg::result_t res_q;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0] ram_rd;
  logic [31:0] off;
  logic [7:0] cur_byte;

  // Opcode decode for the execute step.
  state_e      ex_state;
  logic [15:0] ex_mask;
  logic        ex_set_sp, ex_fin, ex_sp_we;
  logic [31:0] ex_sp;
  logic [3:0]  ex_status;

  assign off = vsp_q - stack_base_i;
  assign cur_byte = word_q[{bidx_q, 3'b000} +: 8];
  assign ram_we = (state_q == S_IDLE) && q_valid_i && q_ready_o &&
                  (q_item_i.op == ehu_pkg::OP_LOAD) &&
                  ({24'd0, q_item_i.idx} < 32'(StackWords));
  assign ram_addr = ram_we ? AW'(q_item_i.idx) : off[AW+1:2];

  ehu_ram #(.Width(32), .Depth(StackWords)) u_store (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(q_item_i.value), .rdata_o(ram_rd)
  );

  assign q_ready_o   = (state_q == S_IDLE) && !res_v_q;
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  logic [3:0] low_dst;
  always_comb begin
    low_dst = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (mask_q[i]) low_dst = 4'(i);
    end
  end

  always_comb begin
    ex_state  = S_CHECK;
    ex_mask   = 16'd0;
    ex_set_sp = 1'b1;
    ex_fin    = 1'b0;
    ex_sp_we  = 1'b0;
    ex_sp     = regs_q[13];
    ex_status = ehu_pkg::ST_OK;
    priority if (op_q[7:6] == 2'b00) begin
      ex_sp_we = 1'b1;
      ex_sp    = regs_q[13] + {24'd0, op_q[5:0], 2'b00} + 32'd4;
    end else if (op_q[7:6] == 2'b01) begin
      ex_sp_we = 1'b1;
      ex_sp    = regs_q[13] - {24'd0, op_q[5:0], 2'b00} - 32'd4;
    end else if (op_q[7:4] == 4'h8) begin
      if ({op_q[3:0], arg_q} == 12'd0) begin
        ex_status = ehu_pkg::ST_REFUSE;
        ex_state  = S_WAIT;
      end else begin
        ex_mask   = {op_q[3:0], arg_q, 4'd0};
        ex_set_sp = !op_q[1];
        ex_state  = S_READ;
      end
    end else if (op_q[7:4] == 4'h9 && (op_q[3:0] & 4'hd) != 4'hd) begin
      ex_sp_we = 1'b1;
      ex_sp    = regs_q[op_q[3:0]];
    end else if (op_q[7:4] == 4'ha) begin
      // r4 up to r(4+n), plus r14 on bit 3
      ex_mask  = {1'b0, op_q[3], 2'd0, 8'hff >> (3'd7 - op_q[2:0]), 4'd0};
      ex_state = S_READ;
    end else if (op_q == 8'hb0) begin
      ex_fin = 1'b1;
    end else if (op_q == 8'hb1) begin
      if (arg_q == 8'd0 || arg_q[7:4] != 4'd0) begin
        ex_status = ehu_pkg::ST_SPARE;
        ex_state  = S_WAIT;
      end else begin
        ex_mask  = {12'd0, arg_q[3:0]};
        ex_state = S_READ;
      end
    end else if (op_q == 8'hb2) begin
      ex_sp_we = 1'b1;
      ex_sp    = regs_q[13] + 32'h204 + {22'd0, arg_q, 2'b00};
    end else begin
      ex_status = ehu_pkg::ST_UNHAND;
      ex_state  = S_WAIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_IDLE;
      res_v_q <= 1'b0;
      pend_v_q <= 1'b0;
      pend_q <= 8'd0;
      words_left_q <= 9'd0;
      sp_low_q <= 32'd0;
      sp_high_q <= 32'd0;
      start_pc_q <= 32'd0;
      for (int i = 0; i < 16; i++) regs_q[i] <= 32'd0;
    end else begin
      if (res_v_q && res_ready_i) res_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i && q_ready_o) begin
            unique case (q_item_i.op)
              ehu_pkg::OP_BEGIN: begin
                for (int i = 0; i < 16; i++) begin
                  if (i == 11) regs_q[i] <= q_item_i.fp;
                  else if (i == 13) regs_q[i] <= q_item_i.sp;
                  else if (i == 14) regs_q[i] <= q_item_i.lr;
                  else regs_q[i] <= 32'd0;
                end
                start_pc_q <= q_item_i.pc;
                sp_low_q <= q_item_i.sp;
                if (stack_top_i != 32'd0)
                  sp_high_q <= (q_item_i.sp > stack_top_i) ? q_item_i.sp : stack_top_i;
                else
                  sp_high_q <= q_item_i.sp + 32'h100;
                words_left_q <= 9'd0;
                pend_v_q <= 1'b0;
                pend_q <= 8'd0;
                phase_q <= PH_FIRST;
              end
              ehu_pkg::OP_ENTRY: begin
                word_q <= q_item_i.value;
                flush_q <= 1'b0;
                priority if (phase_q == PH_FIRST) begin
                  if (q_item_i.value == 32'd1) begin
                    res_q <= '{ehu_pkg::ST_CANT, 32'd0, 32'd0, 32'd0, 32'd0};
                    res_v_q <= 1'b1;
                    phase_q <= PH_IDLE;
                  end else if (q_item_i.value[31:24] == 8'h80) begin
                    nbytes_q <= 3'd3;
                    bidx_q <= 2'd2;
                    words_left_q <= 9'd0;
                    phase_q <= PH_BODY;
                    state_q <= S_BYTE;
                  end else if (q_item_i.value[31:24] == 8'h81) begin
                    nbytes_q <= 3'd2;
                    bidx_q <= 2'd1;
                    words_left_q <= {1'b0, q_item_i.value[23:16]};
                    phase_q <= PH_BODY;
                    state_q <= S_BYTE;
                  end else begin
                    res_q <= '{ehu_pkg::ST_BADPERS, 32'd0, 32'd0, 32'd0, 32'd0};
                    res_v_q <= 1'b1;
                    phase_q <= PH_IDLE;
                  end
                end else if (phase_q == PH_BODY) begin
                  if (words_left_q != 9'd0) words_left_q <= words_left_q - 9'd1;
                  nbytes_q <= 3'd4;
                  bidx_q <= 2'd3;
                  state_q <= S_BYTE;
                end else begin
                  state_q <= S_IDLE;
                end
              end
              default: ;
            endcase
          end
        end
        S_BYTE: begin
          priority if (nbytes_q == 3'd0) begin
            state_q <= S_END;
          end else begin
            nbytes_q <= nbytes_q - 3'd1;
            bidx_q <= bidx_q - 2'd1;
            if (pend_v_q) begin
              pend_v_q <= 1'b0;
              op_q <= pend_q;
              arg_q <= cur_byte;
              state_q <= S_EXEC;
            end else if (cur_byte[7:4] == 4'h8 || cur_byte == 8'hb1 ||
                         cur_byte == 8'hb2) begin
              pend_q <= cur_byte;
              pend_v_q <= 1'b1;
            end else begin
              op_q <= cur_byte;
              arg_q <= 8'd0;
              state_q <= S_EXEC;
            end
          end
        end
        S_END: begin
          if (words_left_q != 9'd0) begin
            state_q <= S_IDLE;
          end else if (pend_v_q) begin
            pend_v_q <= 1'b0;
            op_q <= pend_q;
            arg_q <= 8'd0;
            flush_q <= 1'b1;
            state_q <= S_EXEC;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_EXEC: begin
          vsp_q <= regs_q[13];
          fin_q <= ex_fin;
          mask_q <= ex_mask;
          set_sp_q <= ex_set_sp;
          state_q <= ex_state;
          if (ex_sp_we) regs_q[13] <= ex_sp;
          if (ex_state == S_WAIT)
            res_q <= '{ex_status, 32'd0, 32'd0, 32'd0, 32'd0};
        end
        S_READ: begin
          // One pop per pass: check the address, then wait for read data.
          priority if (mask_q == 16'd0) begin
            if (set_sp_q) regs_q[13] <= vsp_q;
            state_q <= S_CHECK;
          end else if (off[1:0] != 2'd0 || (off >> 2) >= 32'(StackWords)) begin
            res_q <= '{ehu_pkg::ST_OUTSIDE, 32'd0, 32'd0, 32'd0, 32'd0};
            state_q <= S_WAIT;
          end else begin
            dst_q <= low_dst;
            state_q <= S_WAIT;
            fin_q <= 1'b1;
          end
        end
        S_WAIT: begin
          if (state_q == S_WAIT && res_q.status != ehu_pkg::ST_OK && !fin_q) begin
            res_v_q <= 1'b1;
            phase_q <= PH_IDLE;
            pend_v_q <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            regs_q[dst_q] <= ram_rd;
            mask_q[dst_q] <= 1'b0;
            vsp_q <= vsp_q + 32'd4;
            fin_q <= 1'b0;
            state_q <= S_READ;
          end
        end
        S_CHECK: begin
          if (regs_q[13] < sp_low_q || regs_q[13] >= sp_high_q) begin
            res_q <= '{ehu_pkg::ST_SPRANGE, 32'd0, 32'd0, 32'd0, 32'd0};
            res_v_q <= 1'b1;
            phase_q <= PH_IDLE;
            pend_v_q <= 1'b0;
            state_q <= S_IDLE;
          end else if (fin_q) begin
            state_q <= S_FIN;
          end else if (flush_q) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_BYTE;
          end
        end
        S_FIN: begin
          logic [31:0] pc;
          pc = (regs_q[15] == 32'd0) ? regs_q[14] : regs_q[15];
          regs_q[15] <= pc;
          if (pc == start_pc_q)
            res_q <= '{ehu_pkg::ST_PCLOOP, 32'd0, 32'd0, 32'd0, 32'd0};
          else
            res_q <= '{ehu_pkg::ST_OK, regs_q[11], regs_q[13], regs_q[14], pc};
          res_v_q <= 1'b1;
          phase_q <= PH_IDLE;
          pend_v_q <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/ehu_checker.sv */
// ----------------------------------------------------------------------------
// ehu_checker
// Port-level checks for the unwind block.
// ----------------------------------------------------------------------------
module ehu_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);
  // Hold a stalled result.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // Status never exceeds the defined codes.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd8)
    else $error("bad status");
  // Error results carry a zero frame.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3:0] != 4'd0 |-> m_axis_tdata[131:4] == '0)
    else $error("nonzero frame on error");
endmodule

bind ehabi_unwind_interpreter_unit ehu_checker u_ehu_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

/* bench/ehabi_unwind_interpreter_unit_tb.sv */
// ----------------------------------------------------------------------------
// ehabi_unwind_interpreter_unit_tb
// Self-checking bench for the EHABI single-frame unwinder. Preloads the stack
// store, runs directed frames and then random unwind entries under several
// stack base / stack top settings, predicting each frame result in a
// scoreboard and comparing it field by field with m_axis.
// ----------------------------------------------------------------------------
module ehabi_unwind_interpreter_unit_tb;

  localparam int unsigned WORDS     = 256;
  localparam int unsigned LIMIT     = 3000000;
  localparam int unsigned DRAIN     = 400;
  localparam int unsigned PH_IDLE   = 0;
  localparam int unsigned PH_FIRST  = 1;
  localparam int unsigned PH_BODY   = 2;
  localparam logic        REG_BASE  = ehu_pkg::REG_STACK_BASE;
  localparam logic        REG_TOP   = ehu_pkg::REG_STACK_TOP;

  class unwind_scoreboard;
    logic [31:0] stack_base, stack_top;
    logic [31:0] vregs[16];
    logic [31:0] store[WORDS];
    logic [31:0] sp_lo, sp_hi, begin_pc;
    int unsigned entry_left, phase;
    logic [7:0]  held_op;
    bit          held;
    ehu_pkg::result_t frames_due[$];
    int unsigned mismatches;

    function new();
      stack_base = '0;
      stack_top  = '0;
      foreach (vregs[i]) vregs[i] = '0;
      foreach (store[i]) store[i] = '0;
      sp_lo = '0; sp_hi = '0; begin_pc = '0;
      entry_left = 0; phase = PH_IDLE; held_op = '0; held = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] v);
      if (idx == REG_BASE) stack_base = v;
      else stack_top = v;
    endfunction

    function void emit(logic [3:0] st);
      ehu_pkg::result_t r;
      r = '0;
      r.status = st;
      if (st == ehu_pkg::ST_OK) begin
        r.fp = vregs[11]; r.sp = vregs[13]; r.lr = vregs[14]; r.pc = vregs[15];
      end
      frames_due.push_back(r);
      phase = PH_IDLE;
      held  = 0;
    endfunction

    function logic [3:0] pop(inout logic [31:0] vsp, output logic [31:0] d);
      logic [31:0] off;
      off = vsp - stack_base;
      d = '0;
      if (off[1:0] != 2'd0 || off[31:2] >= WORDS) return ehu_pkg::ST_OUTSIDE;
      d = store[off[9:2]];
      vsp = vsp + 32'd4;
      return ehu_pkg::ST_OK;
    endfunction

    function logic [3:0] exec(logic [7:0] op, logic [7:0] arg, output bit fin);
      logic [31:0] vsp, d;
      logic [11:0] mask;
      logic [3:0]  st;
      vsp = vregs[13];
      fin = 0;
      if (op[7:6] == 2'b00) begin
        vregs[13] = vregs[13] + {op[5:0], 2'b00} + 32'd4;
      end else if (op[7:6] == 2'b01) begin
        vregs[13] = vregs[13] - ({op[5:0], 2'b00} + 32'd4);
      end else if (op[7:4] == 4'h8) begin
        mask = {op[3:0], arg};
        if (mask == '0) return ehu_pkg::ST_REFUSE;
        for (int r = 0; r < 12; r++) begin
          if (mask[r]) begin
            st = pop(vsp, d);
            if (st != ehu_pkg::ST_OK) return st;
            vregs[4+r] = d;
          end
        end
        if (!mask[9]) vregs[13] = vsp;
      end else if (op[7:4] == 4'h9 && op[3:0] != 4'd13 && op[3:0] != 4'd15) begin
        vregs[13] = vregs[op[3:0]];
      end else if (op[7:4] == 4'ha) begin
        for (int r = 4; r <= 4 + op[2:0]; r++) begin
          st = pop(vsp, d);
          if (st != ehu_pkg::ST_OK) return st;
          vregs[r] = d;
        end
        if (op[3]) begin
          st = pop(vsp, d);
          if (st != ehu_pkg::ST_OK) return st;
          vregs[14] = d;
        end
        vregs[13] = vsp;
      end else if (op == 8'hb0) begin
        fin = 1;
      end else if (op == 8'hb1) begin
        if (arg == '0 || arg[7:4] != 4'h0) return ehu_pkg::ST_SPARE;
        for (int r = 0; r < 4; r++) begin
          if (arg[r]) begin
            st = pop(vsp, d);
            if (st != ehu_pkg::ST_OK) return st;
            vregs[r] = d;
          end
        end
        vregs[13] = vsp;
      end else if (op == 8'hb2) begin
        vregs[13] = vregs[13] + 32'h204 + {22'd0, arg, 2'b00};
      end else begin
        return ehu_pkg::ST_UNHAND;
      end
      return ehu_pkg::ST_OK;
    endfunction

    function void close_frame();
      if (vregs[15] == '0) vregs[15] = vregs[14];
      if (vregs[15] == begin_pc) emit(ehu_pkg::ST_PCLOOP);
      else emit(ehu_pkg::ST_OK);
    endfunction

    // Returns 1 once the frame has produced its result.
    function bit run(logic [7:0] op, logic [7:0] arg);
      logic [3:0] st;
      bit fin;
      st = exec(op, arg, fin);
      if (st != ehu_pkg::ST_OK) begin
        emit(st);
        return 1;
      end
      if (vregs[13] < sp_lo || vregs[13] >= sp_hi) begin
        emit(ehu_pkg::ST_SPRANGE);
        return 1;
      end
      if (fin) begin
        close_frame();
        return 1;
      end
      return 0;
    endfunction

    function bit feed(logic [7:0] b);
      if (held) begin
        held = 0;
        return run(held_op, b);
      end
      if (b[7:4] == 4'h8 || b == 8'hb1 || b == 8'hb2) begin
        held_op = b;
        held = 1;
        return 0;
      end
      return run(b, 8'h00);
    endfunction

    function void note(ehu_pkg::item_t it);
      int first;
      if (it.op == ehu_pkg::OP_LOAD) begin
        store[it.idx] = it.value;
        return;
      end
      if (it.op == ehu_pkg::OP_BEGIN) begin
        foreach (vregs[i]) vregs[i] = '0;
        vregs[11] = it.fp; vregs[13] = it.sp; vregs[14] = it.lr;
        begin_pc = it.pc;
        sp_lo = it.sp;
        if (stack_top != '0) sp_hi = (sp_lo > stack_top) ? sp_lo : stack_top;
        else sp_hi = sp_lo + 32'h100;
        entry_left = 0; held = 0; held_op = '0;
        phase = PH_FIRST;
        return;
      end
      if (it.op != ehu_pkg::OP_ENTRY) return;
      if (phase == PH_FIRST) begin
        if (it.value == 32'd1) begin
          emit(ehu_pkg::ST_CANT);
          return;
        end
        if (it.value[31:24] == 8'h80) begin
          first = 2; entry_left = 0;
        end else if (it.value[31:24] == 8'h81) begin
          first = 1; entry_left = it.value[23:16];
        end else begin
          emit(ehu_pkg::ST_BADPERS);
          return;
        end
        phase = PH_BODY;
      end else if (phase == PH_BODY) begin
        if (entry_left > 0) entry_left--;
        first = 3;
      end else begin
        return;
      end
      for (int b = first; b >= 0; b--) begin
        if (feed(it.value[8*b +: 8])) return;
      end
      if (entry_left == 0) begin
        if (held) begin
          held = 0;
          if (run(held_op, 8'h00)) return;
        end
        close_frame();
      end
    endfunction

    function void check(ehu_pkg::result_t got);
      ehu_pkg::result_t want;
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = frames_due.pop_front();
      if (got.status != want.status || got.fp != want.fp || got.sp != want.sp ||
          got.lr != want.lr || got.pc != want.pc) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status %0d/%0d fp %h/%h sp %h/%h lr %h/%h pc %h/%h (exp/act)",
                   want.status, got.status, want.fp, got.fp, want.sp, got.sp,
                   want.lr, got.lr, want.pc, got.pc);
      end
    endfunction
  endclass

  logic         clk_i, rst_ni;
  logic         cfg_we_i, cfg_index_i;
  logic [31:0]  cfg_wdata_i;
  logic         s_axis_tvalid, s_axis_tready;
  logic [167:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready;
  logic [135:0] m_axis_tdata;

  unwind_scoreboard sb;
  int unsigned cycles;
  int unsigned burst_left;
  bit          no_gaps;
  int unsigned stall_mode, stall_left;
  logic [31:0] cur_base;

  ehabi_unwind_interpreter_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: switch between always ready, random and long stalls.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    ehu_pkg::item_t   it;
    ehu_pkg::result_t res;
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      it.op    = s_axis_tuser;
      it.idx   = s_axis_tdata[7:0];
      it.value = s_axis_tdata[39:8];
      it.fp    = s_axis_tdata[71:40];
      it.sp    = s_axis_tdata[103:72];
      it.lr    = s_axis_tdata[135:104];
      it.pc    = s_axis_tdata[167:136];
      sb.note(it);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      res.status = m_axis_tdata[3:0];
      res.fp     = m_axis_tdata[35:4];
      res.sp     = m_axis_tdata[67:36];
      res.lr     = m_axis_tdata[99:68];
      res.pc     = m_axis_tdata[131:100];
      sb.check(res);
    end
  end

  task automatic send(logic [1:0] op, logic [7:0] idx, logic [31:0] value,
                      logic [31:0] fp, logic [31:0] sp, logic [31:0] lr,
                      logic [31:0] pc);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {pc, lr, sp, fp, value, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic begin_frame(logic [31:0] sp, logic [31:0] lr, logic [31:0] pc);
    send(ehu_pkg::OP_BEGIN, 8'($urandom), $urandom, $urandom, sp, lr, pc);
  endtask

  task automatic entry(logic [31:0] w);
    send(ehu_pkg::OP_ENTRY, 8'($urandom), w, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Hold until every frame result is out, then let the back stage settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.frames_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, v);
    if (idx == REG_BASE) cur_base = v;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_opcode();
    case ($urandom_range(0, 11))
      0, 1:    return {2'b00, 6'($urandom_range(0, 12))};
      2:       return {2'b01, 6'($urandom)};
      3:       return 8'($urandom_range(8'h80, 8'h8f));
      4:       return 8'($urandom_range(8'h90, 8'h9f));
      5, 6:    return 8'($urandom_range(8'ha0, 8'haf));
      7:       return 8'hb0;
      8:       return 8'hb1;
      9:       return 8'hb2;
      10:      return {2'b00, 6'($urandom)};
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_body();
    logic [31:0] w;
    for (int b = 0; b < 4; b++) begin
      w[8*b +: 8] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 15)) : rand_opcode();
    end
    return w;
  endfunction

  task automatic random_frame();
    logic [31:0] sp, lr, pc, w;
    int unsigned more;
    case ($urandom_range(0, 9))
      0:       sp = $urandom;
      1:       sp = cur_base + $urandom_range(0, 1023);
      default: sp = cur_base + 4 * $urandom_range(0, 200);
    endcase
    lr = $urandom;
    pc = ($urandom_range(0, 7) == 0) ? lr : $urandom;
    begin_frame(sp, lr, pc);
    case ($urandom_range(0, 19))
      0: begin
        entry(32'd1);
        return;
      end
      1: begin
        entry($urandom);
        return;
      end
      2, 3, 4, 5, 6, 7: begin
        w = rand_body();
        entry({8'h80, w[23:0]});
        more = 0;
      end
      default: begin
        more = $urandom_range(0, 3);
        w = rand_body();
        entry({8'h81, 8'(more), w[15:0]});
      end
    endcase
    for (int i = 0; i < more; i++) entry(rand_body());
    // Stray entry words past the result are dropped.
    if ($urandom_range(0, 4) == 0) entry(rand_body());
  endtask

  task automatic noise();
    case ($urandom_range(0, 2))
      0: send(ehu_pkg::OP_LOAD, 8'($urandom), $urandom, $urandom, $urandom, $urandom,
              $urandom);
      1: send(ehu_pkg::OP_NONE, 8'($urandom), $urandom, $urandom, $urandom, $urandom,
              $urandom);
      default: entry($urandom);
    endcase
  endtask

  task automatic random_phase(int unsigned n);
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) noise();
      else random_frame();
    end
    no_gaps = 0;
  endtask

  initial begin
    logic [31:0] b;
    sb = new();
    cycles = 0; burst_left = 0; no_gaps = 0;
    stall_mode = 0; stall_left = 0; cur_base = '0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ehu_pkg::OP_LOAD;
    m_axis_tready <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(REG_BASE, 32'h0000_1000);
    write_reg(REG_TOP, 32'h0);
    // Fill the whole store so no pop ever reads an unwritten word.
    for (int i = 0; i < WORDS; i++) begin
      b = $urandom;
      if (i % 7 == 3) b = 32'h0000_1000 + 4 * $urandom_range(0, 60);
      send(ehu_pkg::OP_LOAD, 8'(i), b, '0, '0, '0, '0);
    end

    // Directed frames.
    b = 32'h0000_1000;
    begin_frame(b, 32'hffff_ffff, 32'h0);    entry(32'd1);           // can't unwind
    begin_frame(b, 32'h0, 32'h0);            entry(32'h7f00_0000);   // bad personality
    begin_frame(b, 32'h1234, 32'h0);         entry(32'h80b0_b0b0);   // finish
    begin_frame(b, 32'h1234, 32'h1234);      entry(32'h80b0_b0b0);   // pc loop
    begin_frame(b, 32'h5, 32'h0);            entry(32'h8080_00b0);   // zero pop mask
    begin_frame(b, 32'h5, 32'h0);            entry(32'h80b1_00b0);   // spare
    begin_frame(b, 32'h5, 32'h0);            entry(32'h809d_b0b0);   // 9d unhandled
    begin_frame(b, 32'h5, 32'h0);            entry(32'h809f_b0b0);   // 9f unhandled
    begin_frame(b, 32'h5, 32'h0);            entry(32'h80ff_b0b0);   // unknown byte
    begin_frame(b, 32'h5, 32'h0);            entry(32'h80af_3fb0);   // long pop and add
    begin_frame(b, 32'h5, 32'h0);            entry(32'h8040_b0b0);   // below sp low
    begin_frame(b + 1, 32'h5, 32'h0);        entry(32'h80a0_b0b0);   // unaligned pop
    begin_frame(b, 32'h5, 32'h0);            entry(32'h808f_ffb0);   // pop all r4-r15
    begin_frame(b, 32'h5, 32'h0);            entry(32'h8000_00b1);   // b1 past last word
    begin_frame(b, 32'h5, 32'h0);            entry(32'h8100_b201);   // b2 operand
    begin_frame(b, 32'h5, 32'h0);            entry(32'h8102_0f00);   // spans words
    entry(32'hb10f_9bb0);
    entry(32'h00b1_0000);
    begin_frame(b, 32'h5, 32'h0);            entry(32'h8101_b0b0);   // restart
    begin_frame(b, 32'h6, 32'h0);            entry(32'h80b0_b0b0);
    entry(32'h80b0_b0b0);                                             // idle entry word
    send(ehu_pkg::OP_NONE, '1, '1, '1, '1, '1, '1);
    drain();

    random_phase(50);
    drain();

    write_reg(REG_BASE, 32'hffff_ff00);
    write_reg(REG_TOP, 32'hffff_ffff);
    random_phase(45);
    drain();

    write_reg(REG_BASE, 32'h0);
    write_reg(REG_TOP, 32'h0000_0010);
    random_phase(20);
    drain();

    write_reg(REG_BASE, 32'h8000_0000);
    write_reg(REG_TOP, 32'h8000_0300);
    random_phase(50);
    drain();

    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ehu_pkg.sv
rtl/core/ehu_ram.sv
rtl/core/ehu_queue.sv
rtl/core/ehu_front.sv
rtl/core/ehu_back.sv
rtl/core/ehabi_unwind_interpreter_unit.sv
rtl/core/ehu_checker.sv
bench/ehabi_unwind_interpreter_unit_tb.sv
